>>> hdl/bms_pkg.sv
package bms_pkg;

  localparam int ACTIVE_W = 4;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 3;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

  localparam logic REG_ACTIVE = 1'b0;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_POP
  } state_t;

endpackage

>>> hdl/bms_ram.sv
module bms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/balanced_multi_stack_top.sv
// Balanced multi-stack: a set of LIFO stacks with one fill count each.
// Input channel: an operation word (in_kind, in_value) is taken at a rising
// edge with start high and busy low. A push goes to the least-filled active
// stack, a pop takes the top of the fullest one; ties go to the lowest index.
// Result channel: out_valid marks one cycle carrying out_status,
// out_stack_index and out_result_value. The receiver cannot stall; every
// result is taken in the cycle it is shown.
// Sequence, with n active stacks: the fill-count memory is scanned one stack
// per cycle in S_SCAN; S_ACT then updates the fill count (and for a push
// writes the stack storage) unless the stack is full or empty, and a pop goes on
// to S_POP for the stack-storage read. busy is high while in these states; the next
// word can be taken in the cycle the result is shown, not while one is in flight.
// Configuration: APB register active_stacks at byte address 0; the user must
// write it only while the block is idle, as the block itself does not enforce this.
// Reset (rst_n low, synchronous): all fill counts read as zero through
// per-stack valid flags, active_stacks returns to 8, no result pending.
// Stack storage is not cleared; only written entries are ever popped.
module balanced_multi_stack_top #(
  parameter int MAX_STACKS  = 8,
  parameter int STACK_DEPTH = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_kind,
  input  logic [bms_pkg::VALUE_W-1:0]    in_value,
  output logic                           out_valid,
  output logic [bms_pkg::STATUS_W-1:0]   out_status,
  output logic [bms_pkg::INDEX_W-1:0]    out_stack_index,
  output logic [bms_pkg::VALUE_W-1:0]    out_result_value,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bms_pkg::PADDR_W-1:0]    paddr,
  input  logic [bms_pkg::PDATA_W-1:0]    pwdata,
  output logic [bms_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);

  import bms_pkg::*;

  localparam int SW    = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
  localparam int CW    = $clog2(STACK_DEPTH + 1);
  localparam int SLOTS = MAX_STACKS * STACK_DEPTH;
  localparam int SAW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  state_t                state_r, state_nxt;
  logic [ACTIVE_W-1:0]   active_r;
  logic                  kind_r;
  logic [VALUE_W-1:0]    value_r;
  logic [SW-1:0]         last_r, last_nxt;
  logic [SW-1:0]         chk_r, chk_nxt;
  logic [SW-1:0]         best_r, best_nxt;
  logic [CW-1:0]         bestcnt_r, bestcnt_nxt;
  logic [MAX_STACKS-1:0] fc_vld_r;
  logic                  fc_vld_q_r;

  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [SW-1:0]         out_idx_r, out_idx_nxt;
  logic [VALUE_W-1:0]    out_value_r, out_value_nxt;

  logic                  accept;
  logic                  cfg_wr;
  logic [CW-1:0]         cnt_cur;
  logic                  better;

  logic [SW-1:0]         fc_raddr;
  logic [CW-1:0]         fc_rdata;
  logic                  fc_we;
  logic [SW-1:0]         fc_waddr;
  logic [CW-1:0]         fc_wdata;

  logic                  st_we;
  logic [SAW-1:0]        st_addr;
  logic [VALUE_W-1:0]    st_rdata;
  logic [CW-1:0]         slot_cnt;

  bms_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_STACKS)
  ) u_fill_ram (
    .clk   (clk),
    .we    (fc_we),
    .waddr (fc_waddr),
    .wdata (fc_wdata),
    .raddr (fc_raddr),
    .rdata (fc_rdata)
  );

  bms_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (SLOTS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_addr),
    .wdata (value_r),
    .raddr (st_addr),
    .rdata (st_rdata)
  );

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ACTIVE);
  assign prdata = (paddr[2] == REG_ACTIVE) ? PDATA_W'(active_r) : '0;

  always_comb begin
    if (active_r == '0) begin
      last_nxt = '0;
    end else if (32'(active_r) > 32'(MAX_STACKS)) begin
      last_nxt = SW'(MAX_STACKS - 1);
    end else begin
      last_nxt = SW'(active_r - ACTIVE_W'(1));
    end
  end

  assign cnt_cur  = fc_vld_q_r ? fc_rdata : '0;
  assign better   = (kind_r == KIND_POP) ? (cnt_cur > bestcnt_r) : (cnt_cur < bestcnt_r);
  assign slot_cnt = (kind_r == KIND_POP) ? (bestcnt_r - CW'(1)) : bestcnt_r;
  assign st_addr  = SAW'(best_r) * SAW'(STACK_DEPTH) + SAW'(slot_cnt);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (chk_r == last_r) begin
          state_nxt = S_ACT;
        end
      end
      S_ACT: begin
        if (kind_r == KIND_POP && bestcnt_r != '0) begin
          state_nxt = S_POP;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_POP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    chk_nxt        = chk_r;
    best_nxt       = best_r;
    bestcnt_nxt    = bestcnt_r;
    fc_raddr       = '0;
    fc_we          = 1'b0;
    fc_waddr       = best_r;
    fc_wdata       = bestcnt_r;
    st_we          = 1'b0;
    out_valid_nxt  = 1'b0;
    out_status_nxt = STAT_DONE;
    out_idx_nxt    = '0;
    out_value_nxt  = '0;
    unique case (state_r)
      S_IDLE: begin
        chk_nxt = '0;
      end
      S_SCAN: begin
        fc_raddr = chk_r + SW'(1);
        chk_nxt  = chk_r + SW'(1);
        if (chk_r == '0 || better) begin
          best_nxt    = chk_r;
          bestcnt_nxt = cnt_cur;
        end
      end
      S_ACT: begin
        if (kind_r == KIND_PUSH) begin
          out_valid_nxt = 1'b1;
          if (bestcnt_r == DEPTH_C) begin
            out_status_nxt = STAT_FULL;
          end else begin
            st_we         = 1'b1;
            fc_we         = 1'b1;
            fc_wdata      = bestcnt_r + CW'(1);
            out_idx_nxt   = best_r;
            out_value_nxt = value_r;
          end
        end else if (bestcnt_r == '0) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_EMPTY;
        end else begin
          fc_we    = 1'b1;
          fc_wdata = bestcnt_r - CW'(1);
        end
      end
      S_POP: begin
        out_valid_nxt = 1'b1;
        out_idx_nxt   = best_r;
        out_value_nxt = st_rdata;
      end
      default: begin
        chk_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= ACTIVE_RESET;
      fc_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        active_r <= pwdata[ACTIVE_W-1:0];
      end
      if (fc_we) begin
        fc_vld_r[fc_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= in_kind;
      value_r <= in_value;
      last_r  <= last_nxt;
    end
    chk_r        <= chk_nxt;
    best_r       <= best_nxt;
    bestcnt_r    <= bestcnt_nxt;
    fc_vld_q_r   <= fc_vld_r[fc_raddr];
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_stack_index  = INDEX_W'(out_idx_r);
  assign out_result_value = out_value_r;

  a_result_when_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_IDLE)
    else $error("result shown while an operation is in flight");

  a_accept_starts_scan : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_SCAN)
    else $error("accepted word did not start the scan");

  a_count_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    fc_we |-> fc_wdata <= DEPTH_C)
    else $error("fill count written beyond stack depth");

  a_storage_write_in_act : assert property (@(posedge clk) disable iff (!rst_n)
    st_we |-> (state_r == S_ACT && kind_r == KIND_PUSH && bestcnt_r != DEPTH_C))
    else $error("stack storage written outside an accepted push");

endmodule

>>> verif/tb_balanced_multi_stack_top.sv
module tb_balanced_multi_stack_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bms_pkg::*;

  localparam int NUM_STACKS = 8;
  localparam int DEPTH      = 5;
  localparam int SETTLE     = 16;
  localparam int PHASE_OPS  = 103;
  localparam logic [PADDR_W-1:0] ACTIVE_ADDR = {REG_ACTIVE, 2'b00};
  localparam logic [PADDR_W-1:0] SPARE_ADDR  = ACTIVE_ADDR + 3'd4;

  typedef struct {
    logic               kind;
    logic [VALUE_W-1:0] value;
  } op_word_t;

  typedef struct {
    status_t            status;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
  } stack_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic in_kind = 1'b0;
  logic [VALUE_W-1:0] in_value = '0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic busy;
  logic out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [INDEX_W-1:0] out_stack_index;
  logic [VALUE_W-1:0] out_result_value;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  op_word_t      pending_ops[$];
  stack_result_t expected_results[$];

  logic [ACTIVE_W-1:0] model_active = ACTIVE_RESET;
  logic [2:0]          fill_level[NUM_STACKS] = '{default: '0};
  logic [VALUE_W-1:0]  stack_words[NUM_STACKS][DEPTH];

  int  errors = 0;
  int  hold_cycles = 0;
  bit  no_gaps = 1'b0;
  int  n_push = 0;
  int  n_pop = 0;
  int  n_full = 0;
  int  n_empty = 0;
  int  n_cfg = 0;

  balanced_multi_stack_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_value(in_value),
    .out_valid(out_valid), .out_status(out_status),
    .out_stack_index(out_stack_index), .out_result_value(out_result_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic stack_result_t stack_model_step(op_word_t w);
    stack_result_t r;
    int n;
    int pick;
    n = (model_active == 0) ? 1 : (model_active > NUM_STACKS) ? NUM_STACKS : model_active;
    pick = 0;
    r.status = STAT_DONE;
    r.index = '0;
    r.value = '0;
    for (int i = 1; i < n; i++) begin
      if (w.kind == KIND_POP ? (fill_level[i] > fill_level[pick])
                             : (fill_level[i] < fill_level[pick]))
        pick = i;
    end
    if (w.kind == KIND_PUSH) begin
      if (fill_level[pick] >= DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        stack_words[pick][fill_level[pick]] = w.value;
        fill_level[pick] = fill_level[pick] + 3'd1;
        r.index = pick[INDEX_W-1:0];
        r.value = w.value;
      end
    end else begin
      if (fill_level[pick] == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        fill_level[pick] = fill_level[pick] - 3'd1;
        r.value = stack_words[pick][fill_level[pick]];
        r.index = pick[INDEX_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic op_word_t random_op(int push_pct);
    op_word_t w;
    int r;
    w.kind = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
    r = $urandom_range(0, 99);
    if (r < 8)
      w.value = 32'h8000_0000;
    else if (r < 16)
      w.value = 32'h7fff_ffff;
    else if (r < 20)
      w.value = '0;
    else if (r < 24)
      w.value = '1;
    else
      w.value = $urandom;
    return w;
  endfunction

  function automatic void flag_mismatch(string msg);
    errors++;
    if (errors <= 10)
      $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin
    op_word_t w;
    stack_result_t r;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        w.kind = in_kind;
        w.value = in_value;
        r = stack_model_step(w);
        expected_results.push_back(r);
        if (w.kind == KIND_PUSH) n_push++; else n_pop++;
        if (r.status == STAT_FULL) n_full++;
        if (r.status == STAT_EMPTY) n_empty++;
      end
      if (!start || !busy) begin
        if (hold_cycles > 0 || pending_ops.size() == 0) begin
          if (hold_cycles > 0) hold_cycles--;
          start <= 1'b0;
          in_kind <= 1'($urandom_range(0, 1));
          in_value <= $urandom;
        end else begin
          w = pending_ops.pop_front();
          start <= 1'b1;
          in_kind <= w.kind;
          in_value <= w.value;
          hold_cycles = pick_gap();
        end
      end
    end
  end

  always @(posedge clk) begin
    stack_result_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected word status %0d index %0d value %h",
                                out_status, out_stack_index, out_result_value));
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status || out_stack_index !== want.index ||
            out_result_value !== want.value)
          flag_mismatch($sformatf("status %0d/%0d index %0d/%0d value %h/%h (exp/got)",
                                  want.status, out_status, want.index, out_stack_index,
                                  want.value, out_result_value));
      end
    end
  end

  task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if ((addr >> 2) == REG_ACTIVE)
      model_active = data[ACTIVE_W-1:0];
    n_cfg++;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (pending_ops.size() != 0 || start || expected_results.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic queue_op(input logic kind, input logic [VALUE_W-1:0] value);
    op_word_t w;
    w.kind = kind;
    w.value = value;
    pending_ops.push_back(w);
  endtask

  initial begin
    int setting[8] = '{3, 0, 15, 1, 6, 8, 2, -1};
    int push_pct[8] = '{65, 40, 70, 35, 75, 30, 60, 50};
    int act;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    queue_op(KIND_POP, 32'h1234_5678);
    queue_op(KIND_PUSH, 32'h8000_0000);
    queue_op(KIND_PUSH, 32'h7fff_ffff);
    queue_op(KIND_PUSH, 32'h0000_0000);
    queue_op(KIND_PUSH, 32'hffff_ffff);
    repeat (4) queue_op(KIND_POP, 32'h0);
    wait_idle();

    cfg_write(ACTIVE_ADDR, 32'h0000_0001);
    for (int i = 0; i < 6; i++)
      queue_op(KIND_PUSH, 32'h5a5a_0000 + i);
    for (int i = 0; i < 6; i++)
      queue_op(KIND_POP, $urandom);
    wait_idle();

    cfg_write(SPARE_ADDR, 32'hffff_fff3);
    for (int p = 0; p < 8; p++) begin
      act = (setting[p] < 0) ? $urandom_range(2, 7) : setting[p];
      cfg_write(ACTIVE_ADDR, {28'($urandom_range(0, 32'h0fff_ffff)), act[3:0]});
      no_gaps = (p % 3 == 1);
      for (int i = 0; i < PHASE_OPS; i++)
        pending_ops.push_back(random_op(push_pct[p]));
      wait_idle();
    end
    no_gaps = 1'b0;

    repeat (20) @(posedge clk);
    $display("covered %0d pushes and %0d pops over %0d register writes",
             n_push, n_pop, n_cfg);
    $display("rejections seen: %0d on all-full, %0d on all-empty", n_full, n_empty);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d words outstanding", errors, expected_results.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timed out with %0d words outstanding", expected_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
